// ===== rtl/median_filter_3x3_core_defines.svh =====
// Assertion macros for the 3x3 median filter core.
// Included by the files that check their own logic; depends on nothing else.
`ifndef MEDIAN_FILTER_3X3_CORE_DEFINES_SVH
`define MEDIAN_FILTER_3X3_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MF3_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mf3 check failed: same-cycle implication");
`define MF3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mf3 check failed: next-cycle implication");
`else
`define MF3_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MF3_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/mf3_pkg.sv =====
// Shared constants, types and compare functions of the 3x3 median filter.
// Used by every module of the block; depends on nothing.
package mf3_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int PIX_W       = 8;
   localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WIDTH_W     = 11;
   localparam int ROW_W       = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int MIN_SIDE    = 3;
   localparam int RESET_WIDTH  = 1024;
   localparam int RESET_HEIGHT = 768;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_W'(1);

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type above;
      pixel_type middle;
   } line_pair_type;

   typedef struct packed {
      pixel_type lo;
      pixel_type md;
      pixel_type hi;
   } column_type;

   typedef struct packed {
      logic emit;
      logic last;
   } item_tag_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      column_type [2:0] cols;
   } window_bus_type;

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic column_type sort3(input pixel_type a, input pixel_type b,
                                        input pixel_type c);
      pixel_type  lo1;
      pixel_type  hi1;
      pixel_type  t;
      column_type s;
      lo1  = min2(a, b);
      hi1  = max2(a, b);
      t    = max2(lo1, c);
      s.lo = min2(lo1, c);
      s.md = min2(t, hi1);
      s.hi = max2(t, hi1);
      return s;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

// ===== rtl/mf3_line_store.sv =====
// Line store of the median filter: one synchronous memory holding the two
// previous rows per column, with a registered read. Depends on mf3_pkg.
module mf3_line_store (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [mf3_pkg::COL_W-1:0]  rd_addr,
   output mf3_pkg::line_pair_type     rd_pair,
   input  logic                       wr_en,
   input  logic [mf3_pkg::COL_W-1:0]  wr_addr,
   input  mf3_pkg::line_pair_type     wr_pair
);
   import mf3_pkg::*;

   line_pair_type line_mem_ff [MAX_WIDTH];
   line_pair_type rd_pair_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_pair;
      end
      if (rd_en) begin
         rd_pair_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_pair = rd_pair_ff;

endmodule

// ===== rtl/mf3_window.sv =====
// 3x3 window of the median filter: sorts each incoming column and keeps the
// three newest sorted columns with the result tag. Depends on mf3_pkg.
module mf3_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift,
   input  mf3_pkg::item_tag_type   shift_tag,
   input  mf3_pkg::line_pair_type  rd_pair,
   input  mf3_pkg::pixel_type      new_pixel,
   output logic                    shift_ready,
   output mf3_pkg::window_bus_type win,
   input  logic                    win_ready
);
   import mf3_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   logic             last_ff;
   column_type [2:0] cols_ff;

   assign shift_ready = !valid_ff || win_ready;

   always_comb begin
      valid_in = valid_ff;
      if (shift) begin
         valid_in = shift_tag.emit;
      end else if (valid_ff && win_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         last_ff    <= shift_tag.last;
         cols_ff[0] <= cols_ff[1];
         cols_ff[1] <= cols_ff[2];
         cols_ff[2] <= sort3(rd_pair.above, rd_pair.middle, new_pixel);
      end
   end

   assign win.valid = valid_ff;
   assign win.last  = last_ff;
   assign win.cols  = cols_ff;

endmodule

// ===== rtl/mf3_median.sv =====
// Median selection of the filter: reduces three sorted columns in two
// registered steps and drives the result channel. Depends on mf3_pkg.
module mf3_median (
   input  logic                    clock,
   input  logic                    reset,
   input  mf3_pkg::window_bus_type win,
   output logic                    win_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mf3_pkg::pixel_type      rsp_median,
   output logic                    rsp_frame_end
);
   import mf3_pkg::*;

   logic      s3_valid_ff;
   logic      s3_valid_in;
   logic      s3_last_ff;
   pixel_type s3_lo_ff;
   pixel_type s3_md_ff;
   pixel_type s3_hi_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      out_last_ff;
   pixel_type out_median_ff;
   logic      out_free;
   logic      s3_adv;
   logic      win_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s3_adv    = s3_valid_ff && out_free;
   assign win_ready = !s3_valid_ff || out_free;
   assign win_take  = win.valid && win_ready;

   always_comb begin
      s3_valid_in = s3_valid_ff;
      if (win_take) begin
         s3_valid_in = 1'b1;
      end else if (s3_adv) begin
         s3_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s3_adv) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_take) begin
         s3_last_ff <= win.last;
         s3_lo_ff   <= max2(max2(win.cols[0].lo, win.cols[1].lo), win.cols[2].lo);
         s3_md_ff   <= med3(win.cols[0].md, win.cols[1].md, win.cols[2].md);
         s3_hi_ff   <= min2(min2(win.cols[0].hi, win.cols[1].hi), win.cols[2].hi);
      end
      if (s3_adv) begin
         out_last_ff   <= s3_last_ff;
         out_median_ff <= med3(s3_lo_ff, s3_md_ff, s3_hi_ff);
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_median    = out_median_ff;
   assign rsp_frame_end = out_last_ff;

endmodule

// ===== rtl/median_filter_3x3_core.sv =====
// Top level of the 3x3 median filter: frame counters, configuration
// registers and the pipeline linking line store, window and median stages.
// Depends on mf3_pkg, mf3_line_store, mf3_window, mf3_median and the defines.
//
// Usage:
// Pixels arrive in raster order on the req_ channel, one per transaction.
// For every pixel at row two or later and column two or later, one result
// leaves on the rsp_ channel: the median of the 3x3 neighborhood centered one
// row up and one column left. rsp_frame_end marks the last result of a frame.
// A transaction completes when valid is high and stall is low.
// Throughput is one pixel per cycle while rsp_stall is low, set by the single
// read and the single write of the line store per pixel and the three-stage
// sort and select pipeline.
// When the receiver stalls, results collect in the pipeline registers and
// req_stall rises once they are full; nothing is lost or repeated.
// Register 0 is the frame width, register 1 the frame height, written on the
// csr_ channel while the block is idle; any write to them restarts the frame.
// Reset sets width 1024 and height 768 and restarts the frame. The line
// store needs no clearing pass: its entries are written before they matter.
`include "median_filter_3x3_core_defines.svh"

module median_filter_3x3_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mf3_pkg::PIX_W-1:0]         req_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mf3_pkg::PIX_W-1:0]         rsp_median,
   output logic                              rsp_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mf3_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mf3_pkg::*;

   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic [COL_W-1:0]   wlast_ff;
   logic [COL_W-1:0]   wlast_in;
   logic [ROW_W-1:0]   hlast_ff;
   logic [ROW_W-1:0]   hlast_in;
   logic [WIDTH_W-1:0] width_val;
   logic [ROW_W-1:0]   height_val;
   logic               csr_write;
   logic               csr_known;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   pixel_type          s1_pixel_ff;
   logic [COL_W-1:0]   s1_col_ff;
   item_tag_type       s1_tag_ff;
   item_tag_type       req_tag;
   logic               req_accept;
   logic               s1_adv;

   line_pair_type      rd_pair;
   line_pair_type      wr_pair;
   logic               shift_ready;
   window_bus_type     win;
   logic               win_ready;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign csr_known  = (csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT);
   assign width_val  = csr_wdata[WIDTH_W-1:0];
   assign height_val = csr_wdata[ROW_W-1:0];

   assign s1_adv     = s1_valid_ff && shift_ready;
   assign req_stall  = s1_valid_ff && !shift_ready;
   assign req_accept = req_valid && !req_stall;

   assign req_tag.emit = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign req_tag.last = (row_ff == hlast_ff) && (col_ff == wlast_ff);

   always_comb begin
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (csr_write && csr_known) begin
         col_in = '0;
         row_in = '0;
         if (csr_index == CSR_FRAME_WIDTH) begin
            if (int'(width_val) < MIN_SIDE) begin
               wlast_in = COL_W'(MIN_SIDE - 1);
            end else if (int'(width_val) > MAX_WIDTH) begin
               wlast_in = COL_W'(MAX_WIDTH - 1);
            end else begin
               wlast_in = COL_W'(width_val - WIDTH_W'(1));
            end
         end else begin
            if (int'(height_val) < MIN_SIDE) begin
               hlast_in = ROW_W'(MIN_SIDE - 1);
            end else begin
               hlast_in = height_val - ROW_W'(1);
            end
         end
      end else if (req_accept) begin
         if (col_ff == wlast_ff) begin
            col_in = '0;
            row_in = (row_ff == hlast_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         wlast_ff    <= COL_W'(RESET_WIDTH - 1);
         hlast_ff    <= ROW_W'(RESET_HEIGHT - 1);
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         wlast_ff    <= wlast_in;
         hlast_ff    <= hlast_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_ff;
         s1_tag_ff   <= req_tag;
      end
   end

   assign wr_pair.above  = rd_pair.middle;
   assign wr_pair.middle = s1_pixel_ff;

   mf3_line_store u_line_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_pair (rd_pair),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_pair (wr_pair)
   );

   mf3_window u_window (
      .clock       (clock),
      .reset       (reset),
      .shift       (s1_adv),
      .shift_tag   (s1_tag_ff),
      .rd_pair     (rd_pair),
      .new_pixel   (s1_pixel_ff),
      .shift_ready (shift_ready),
      .win         (win),
      .win_ready   (win_ready)
   );

   mf3_median u_median (
      .clock         (clock),
      .reset         (reset),
      .win           (win),
      .win_ready     (win_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_median    (rsp_median),
      .rsp_frame_end (rsp_frame_end)
   );

   `MF3_ASSERT_IMPLY(a_no_rw_collision, clock, reset, req_accept && s1_adv, s1_col_ff != col_ff)
   `MF3_ASSERT_IMPLY(a_col_in_frame, clock, reset, 1'b1, col_ff <= wlast_ff && row_ff <= hlast_ff)
   `MF3_ASSERT_NEXT(a_frame_wrap, clock, reset, req_accept && req_tag.last, col_ff == '0 && row_ff == '0)

endmodule
